[hdl/capsule_capsule_overlap_test_assert.svh]
// ------------------------------------------------------------------------
// Assertion macros for the capsule overlap test
// Implication helpers used by the top-level file to check the block.
// ------------------------------------------------------------------------
`ifndef CAPSULE_CAPSULE_OVERLAP_TEST_ASSERT_SVH
`define CAPSULE_CAPSULE_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication
`define CCOT_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define CCOT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

[hdl/ccot_pkg.sv]
// ------------------------------------------------------------------------
// ccot_pkg
// Widths, micro-op encoding and microcode for the capsule overlap test.
// ------------------------------------------------------------------------
package ccot_pkg;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int OPW     = 52;
	localparam int ACC_W   = 104;
	localparam int Q_FRAC  = 16;
	localparam int Q_W     = Q_FRAC + 1;
	localparam int CHUNK_W = 16;
	localparam int MAX_CH  = 4;
	localparam int MAG_W   = CHUNK_W * MAX_CH;
	localparam int NCH_W   = 3;
	localparam int PC_W    = 6;
	localparam int SQ_W    = 48;
	localparam int SUM_LSB = 32;
	localparam int CNT_W   = 5;

	localparam logic [Q_W-1:0]  Q_ONE  = Q_W'(1) << Q_FRAC;
	localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

	localparam logic [PC_W-1:0] L_TN  = PC_W'(32);
	localparam logic [PC_W-1:0] L_NEG = PC_W'(40);
	localparam logic [PC_W-1:0] L_GT  = PC_W'(42);
	localparam logic [PC_W-1:0] L_TFE = PC_W'(45);
	localparam logic [PC_W-1:0] L_FIN = PC_W'(47);

	typedef enum logic [4:0] {
		OP_D1X, OP_D1Y, OP_D1Z, OP_D2X, OP_D2Y, OP_D2Z, OP_RX, OP_RY, OP_RZ,
		OP_A, OP_B, OP_C, OP_E, OP_F, OP_S, OP_T, OP_ONE, OP_W0, OP_W1, OP_W2
	} opnd_t;

	typedef enum logic [2:0] {
		UK_MAC, UK_ST, UK_DIV, UK_BR, UK_JMP, UK_SET, UK_OUT
	} ukind_t;

	typedef enum logic [3:0] {
		DST_A, DST_B, DST_C, DST_E, DST_F, DST_N, DST_DN, DST_TD,
		DST_W0, DST_W1, DST_W2
	} dst_t;

	typedef enum logic [1:0] {DV_N_DN, DV_F_E, DV_NEGC_A, DV_BMC_A} dpair_t;

	typedef enum logic [2:0] {
		C_AE_ZERO, C_A_ZERO, C_E_ZERO, C_DN_ZERO, C_N_NEG, C_N_GT
	} cond_t;

	typedef enum logic {SET_CLEAR, SET_T_ONE} setk_t;

	typedef struct packed {
		ukind_t            kind;
		opnd_t             xs;
		opnd_t             ys;
		logic [NCH_W-1:0]  nch;
		logic              neg;
		logic              clr;
		dst_t              dst;
		dpair_t            dpair;
		logic              to_t;
		cond_t             cond;
		setk_t             setk;
		logic [PC_W-1:0]   tgt;
	} uop_t;

	typedef struct packed {
		logic              prep;
		logic              mac_go;
		opnd_t             xs;
		opnd_t             ys;
		logic [NCH_W-1:0]  nch;
		logic              neg;
		logic              clr;
		logic              st_go;
		dst_t              dst;
		logic              div_go;
		dpair_t            dpair;
		logic              div_wr;
		logic              to_t;
		logic              set_go;
		setk_t             setk;
		logic              out_go;
	} cmd_t;

	typedef struct packed {
		logic a_zero;
		logic e_zero;
		logic dn_zero;
		logic n_neg;
		logic n_gt;
		logic mac_done;
		logic div_done;
	} stat_t;

	function automatic uop_t u_nop();
		uop_t u;
		u = '{kind: UK_OUT, xs: OP_D1X, ys: OP_D1X, nch: NCH_W'(1), neg: 1'b0,
			clr: 1'b0, dst: DST_A, dpair: DV_N_DN, to_t: 1'b0, cond: C_AE_ZERO,
			setk: SET_CLEAR, tgt: '0};
		return u;
	endfunction

	function automatic uop_t u_mac(input opnd_t x, input opnd_t y, input int n,
			input logic ng, input logic cl);
		uop_t u;
		u = u_nop();
		u.kind = UK_MAC;
		u.xs = x;
		u.ys = y;
		u.nch = NCH_W'(n);
		u.neg = ng;
		u.clr = cl;
		return u;
	endfunction

	function automatic uop_t u_st(input dst_t d);
		uop_t u;
		u = u_nop();
		u.kind = UK_ST;
		u.dst = d;
		return u;
	endfunction

	function automatic uop_t u_div(input dpair_t p, input logic tt);
		uop_t u;
		u = u_nop();
		u.kind = UK_DIV;
		u.dpair = p;
		u.to_t = tt;
		return u;
	endfunction

	function automatic uop_t u_br(input cond_t c, input logic [PC_W-1:0] t);
		uop_t u;
		u = u_nop();
		u.kind = UK_BR;
		u.cond = c;
		u.tgt = t;
		return u;
	endfunction

	function automatic uop_t u_jmp(input logic [PC_W-1:0] t);
		uop_t u;
		u = u_nop();
		u.kind = UK_JMP;
		u.tgt = t;
		return u;
	endfunction

	function automatic uop_t u_set(input setk_t k);
		uop_t u;
		u = u_nop();
		u.kind = UK_SET;
		u.setk = k;
		return u;
	endfunction

	// Microcode: dot products, Cramer numerators, clamp and recompute of s,
	// then the squared distance of the closest points.
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = u_nop();
		case (pc)
			6'd0:  u = u_mac(OP_D1X, OP_D1X, 2, 1'b0, 1'b1);
			6'd1:  u = u_mac(OP_D1Y, OP_D1Y, 2, 1'b0, 1'b0);
			6'd2:  u = u_mac(OP_D1Z, OP_D1Z, 2, 1'b0, 1'b0);
			6'd3:  u = u_st(DST_A);
			6'd4:  u = u_mac(OP_D2X, OP_D2X, 2, 1'b0, 1'b1);
			6'd5:  u = u_mac(OP_D2Y, OP_D2Y, 2, 1'b0, 1'b0);
			6'd6:  u = u_mac(OP_D2Z, OP_D2Z, 2, 1'b0, 1'b0);
			6'd7:  u = u_st(DST_E);
			6'd8:  u = u_mac(OP_D2X, OP_RX, 2, 1'b0, 1'b1);
			6'd9:  u = u_mac(OP_D2Y, OP_RY, 2, 1'b0, 1'b0);
			6'd10: u = u_mac(OP_D2Z, OP_RZ, 2, 1'b0, 1'b0);
			6'd11: u = u_st(DST_F);
			6'd12: u = u_mac(OP_D1X, OP_RX, 2, 1'b0, 1'b1);
			6'd13: u = u_mac(OP_D1Y, OP_RY, 2, 1'b0, 1'b0);
			6'd14: u = u_mac(OP_D1Z, OP_RZ, 2, 1'b0, 1'b0);
			6'd15: u = u_st(DST_C);
			6'd16: u = u_mac(OP_D1X, OP_D2X, 2, 1'b0, 1'b1);
			6'd17: u = u_mac(OP_D1Y, OP_D2Y, 2, 1'b0, 1'b0);
			6'd18: u = u_mac(OP_D1Z, OP_D2Z, 2, 1'b0, 1'b0);
			6'd19: u = u_st(DST_B);
			6'd20: u = u_set(SET_CLEAR);
			6'd21: u = u_br(C_AE_ZERO, L_FIN);
			6'd22: u = u_br(C_A_ZERO, L_TFE);
			6'd23: u = u_br(C_E_ZERO, L_NEG);
			6'd24: u = u_mac(OP_A, OP_E, 4, 1'b0, 1'b1);
			6'd25: u = u_mac(OP_B, OP_B, 4, 1'b1, 1'b0);
			6'd26: u = u_st(DST_DN);
			6'd27: u = u_mac(OP_B, OP_F, 4, 1'b0, 1'b1);
			6'd28: u = u_mac(OP_C, OP_E, 4, 1'b1, 1'b0);
			6'd29: u = u_st(DST_N);
			6'd30: u = u_br(C_DN_ZERO, L_TN);
			6'd31: u = u_div(DV_N_DN, 1'b0);
			6'd32: u = u_mac(OP_B, OP_S, 2, 1'b0, 1'b1);
			6'd33: u = u_mac(OP_F, OP_ONE, 2, 1'b0, 1'b0);
			6'd34: u = u_st(DST_N);
			6'd35: u = u_st(DST_TD);
			6'd36: u = u_br(C_N_NEG, L_NEG);
			6'd37: u = u_br(C_N_GT, L_GT);
			6'd38: u = u_div(DV_N_DN, 1'b1);
			6'd39: u = u_jmp(L_FIN);
			6'd40: u = u_div(DV_NEGC_A, 1'b0);
			6'd41: u = u_jmp(L_FIN);
			6'd42: u = u_set(SET_T_ONE);
			6'd43: u = u_div(DV_BMC_A, 1'b0);
			6'd44: u = u_jmp(L_FIN);
			6'd45: u = u_div(DV_F_E, 1'b1);
			6'd46: u = u_jmp(L_FIN);
			6'd47: u = u_mac(OP_RX, OP_ONE, 2, 1'b0, 1'b1);
			6'd48: u = u_mac(OP_D1X, OP_S, 2, 1'b0, 1'b0);
			6'd49: u = u_mac(OP_D2X, OP_T, 2, 1'b1, 1'b0);
			6'd50: u = u_st(DST_W0);
			6'd51: u = u_mac(OP_RY, OP_ONE, 2, 1'b0, 1'b1);
			6'd52: u = u_mac(OP_D1Y, OP_S, 2, 1'b0, 1'b0);
			6'd53: u = u_mac(OP_D2Y, OP_T, 2, 1'b1, 1'b0);
			6'd54: u = u_st(DST_W1);
			6'd55: u = u_mac(OP_RZ, OP_ONE, 2, 1'b0, 1'b1);
			6'd56: u = u_mac(OP_D1Z, OP_S, 2, 1'b0, 1'b0);
			6'd57: u = u_mac(OP_D2Z, OP_T, 2, 1'b1, 1'b0);
			6'd58: u = u_st(DST_W2);
			6'd59: u = u_mac(OP_W0, OP_W0, 3, 1'b0, 1'b1);
			6'd60: u = u_mac(OP_W1, OP_W1, 3, 1'b0, 1'b0);
			6'd61: u = u_mac(OP_W2, OP_W2, 3, 1'b0, 1'b0);
			default: u = u_nop();
		endcase
		return u;
	endfunction

endpackage

[hdl/capsule_capsule_overlap_test.sv]
// ------------------------------------------------------------------------
// capsule_capsule_overlap_test
// Closest points between a stored capsule axis and a test capsule axis.
// ------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       mode, start_x/y/z, end_x/y/z, radius
//  result    done (one cycle)   collide, sq_distance
//
// A load request (mode 0) is stored as the reference capsule and leaves busy low.
// A test request holds busy high while it runs on the shared
// signed multiply-accumulate unit (up to 33 passes, each one 52x16 digit product
// a cycle over two to four digits plus issue and accumulate) and the
// one-bit-a-cycle divider (up to two quotients, ended early if clamped).
// Reset clears the reference capsule to zero and returns to idle.
// The result shows for one cycle after busy falls; the receiver cannot stall.
// ------------------------------------------------------------------------
`include "capsule_capsule_overlap_test_assert.svh"

module capsule_capsule_overlap_test (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  mode,
	input  logic signed [ccot_pkg::COORD_W-1:0]   start_x,
	input  logic signed [ccot_pkg::COORD_W-1:0]   start_y,
	input  logic signed [ccot_pkg::COORD_W-1:0]   start_z,
	input  logic signed [ccot_pkg::COORD_W-1:0]   end_x,
	input  logic signed [ccot_pkg::COORD_W-1:0]   end_y,
	input  logic signed [ccot_pkg::COORD_W-1:0]   end_z,
	input  logic [ccot_pkg::RAD_W-1:0]            radius,
	output logic                                  done,
	output logic                                  collide,
	output logic [ccot_pkg::SQ_W-1:0]             sq_distance
);
	ccot_pkg::cmd_t  cmd;
	ccot_pkg::stat_t stat;
	logic            accept;

	assign accept = start && !busy;

	ccot_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ccot_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_z     (start_z),
		.end_x       (end_x),
		.end_y       (end_y),
		.end_z       (end_z),
		.radius      (radius),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.collide     (collide),
		.sq_distance (sq_distance)
	);

	`CCOT_ASSERT_NEXT(a_load_no_busy, clk, arst_n, accept && !mode, !busy && !done)
	`CCOT_ASSERT_NEXT(a_test_busy, clk, arst_n, accept && mode, busy)
	`CCOT_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy && !cmd.out_go)
	`CCOT_ASSERT_NOW(a_collide_unsat, clk, arst_n, done && collide, sq_distance != ccot_pkg::SQ_MAX)

endmodule

[hdl/ccot_mac.sv]
// ------------------------------------------------------------------------
// ccot_mac
// Shared signed multiply-accumulate, one 16-bit digit of y per cycle.
// ------------------------------------------------------------------------
module ccot_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic signed [ccot_pkg::OPW-1:0]       x,
	input  logic signed [ccot_pkg::OPW-1:0]       y,
	input  logic [ccot_pkg::NCH_W-1:0]            nch,
	input  logic                                  neg,
	input  logic                                  clr,
	output logic signed [ccot_pkg::ACC_W-1:0]     acc,
	output logic                                  done
);
	localparam int PROD_W = ccot_pkg::OPW + ccot_pkg::CHUNK_W;

	logic                                busy_q;
	logic [ccot_pkg::NCH_W-1:0]          cnt_q;
	logic [ccot_pkg::OPW-1:0]            xm_q;
	logic [ccot_pkg::MAG_W-1:0]          ym_q;
	logic [ccot_pkg::ACC_W-1:0]          pp_q;
	logic                                sgn_q;
	logic signed [ccot_pkg::ACC_W-1:0]   acc_q;

	logic [ccot_pkg::OPW-1:0]            x_mag;
	logic [ccot_pkg::OPW-1:0]            y_mag;
	logic [ccot_pkg::MAG_W-1:0]          y_ext;
	logic [ccot_pkg::MAG_W-1:0]          y_al;
	logic [PROD_W-1:0]                   prod;
	logic [ccot_pkg::ACC_W-1:0]          pp_next;

	assign x_mag = x[ccot_pkg::OPW-1] ? (~x + 1'b1) : x;
	assign y_mag = y[ccot_pkg::OPW-1] ? (~y + 1'b1) : y;
	assign y_ext = {{(ccot_pkg::MAG_W - ccot_pkg::OPW){1'b0}}, y_mag};

	// left-align the used digits so the top digit goes first
	always_comb begin
		case (nch)
			3'd1: y_al = y_ext << (3 * ccot_pkg::CHUNK_W);
			3'd2: y_al = y_ext << (2 * ccot_pkg::CHUNK_W);
			3'd3: y_al = y_ext << ccot_pkg::CHUNK_W;
			default: y_al = y_ext;
		endcase
	end

	assign prod = {{ccot_pkg::CHUNK_W{1'b0}}, xm_q}
		* {{ccot_pkg::OPW{1'b0}}, ym_q[ccot_pkg::MAG_W-1 -: ccot_pkg::CHUNK_W]};
	assign pp_next = {pp_q[ccot_pkg::ACC_W-ccot_pkg::CHUNK_W-1:0], {ccot_pkg::CHUNK_W{1'b0}}}
		+ {{(ccot_pkg::ACC_W - PROD_W){1'b0}}, prod};

	assign done = busy_q && (cnt_q == '0);
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			xm_q   <= '0;
			ym_q   <= '0;
			pp_q   <= '0;
			sgn_q  <= 1'b0;
			acc_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= nch;
			xm_q   <= x_mag;
			ym_q   <= y_al;
			pp_q   <= '0;
			sgn_q  <= x[ccot_pkg::OPW-1] ^ y[ccot_pkg::OPW-1] ^ neg;
			if (clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				pp_q  <= pp_next;
				ym_q  <= ym_q << ccot_pkg::CHUNK_W;
				cnt_q <= cnt_q - 1'b1;
			end else begin
				acc_q  <= sgn_q ? (acc_q - $signed(pp_q)) : (acc_q + $signed(pp_q));
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/ccot_div.sv]
// ------------------------------------------------------------------------
// ccot_div
// Clamped quotient num/den in unsigned Q1.16, restoring, one bit a cycle.
// ------------------------------------------------------------------------
module ccot_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic signed [ccot_pkg::ACC_W-1:0]     num,
	input  logic signed [ccot_pkg::ACC_W-1:0]     den,
	output logic [ccot_pkg::Q_W-1:0]              q,
	output logic                                  done
);
	logic                                busy_q;
	logic                                chk_q;
	logic [ccot_pkg::CNT_W-1:0]          cnt_q;
	logic signed [ccot_pkg::ACC_W-1:0]   rem_q;
	logic signed [ccot_pkg::ACC_W-1:0]   den_q;
	logic [ccot_pkg::Q_W-1:0]            q_q;

	logic signed [ccot_pkg::ACC_W-1:0]   shl;
	logic signed [ccot_pkg::ACC_W-1:0]   trial;
	logic signed [ccot_pkg::ACC_W-1:0]   diff;
	logic                                le0;
	logic                                ge;

	assign shl   = {rem_q[ccot_pkg::ACC_W-2:0], 1'b0};
	assign trial = shl - den_q;
	assign diff  = rem_q - den_q;
	assign le0   = rem_q[ccot_pkg::ACC_W-1] || (rem_q == '0);
	assign ge    = !diff[ccot_pkg::ACC_W-1];

	assign done = busy_q && ((chk_q && (le0 || ge)) || (!chk_q && (cnt_q == 5'd1)));
	assign q    = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			q_q    <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			chk_q  <= 1'b1;
			rem_q  <= num;
			den_q  <= den;
			q_q    <= '0;
		end else if (busy_q) begin
			if (chk_q) begin
				if (le0) begin
					q_q    <= '0;
					busy_q <= 1'b0;
				end else if (ge) begin
					q_q    <= ccot_pkg::Q_ONE;
					busy_q <= 1'b0;
				end else begin
					chk_q <= 1'b0;
					cnt_q <= ccot_pkg::CNT_W'(ccot_pkg::Q_FRAC);
				end
			end else begin
				rem_q <= trial[ccot_pkg::ACC_W-1] ? shl : trial;
				q_q   <= {q_q[ccot_pkg::Q_W-2:0], !trial[ccot_pkg::ACC_W-1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

[hdl/ccot_dpath.sv]
// ------------------------------------------------------------------------
// ccot_dpath
// Reference capsule, working registers, MAC and divider, result register.
// ------------------------------------------------------------------------
module ccot_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  mode,
	input  logic signed [ccot_pkg::COORD_W-1:0]   start_x,
	input  logic signed [ccot_pkg::COORD_W-1:0]   start_y,
	input  logic signed [ccot_pkg::COORD_W-1:0]   start_z,
	input  logic signed [ccot_pkg::COORD_W-1:0]   end_x,
	input  logic signed [ccot_pkg::COORD_W-1:0]   end_y,
	input  logic signed [ccot_pkg::COORD_W-1:0]   end_z,
	input  logic [ccot_pkg::RAD_W-1:0]            radius,
	input  ccot_pkg::cmd_t                        cmd,
	output ccot_pkg::stat_t                       stat,
	output logic                                  done,
	output logic                                  collide,
	output logic [ccot_pkg::SQ_W-1:0]             sq_distance
);
	localparam int SUM_TOP = ccot_pkg::SUM_LSB + ccot_pkg::SQ_W;

	logic signed [ccot_pkg::COORD_W-1:0] ref_s_q [3];
	logic signed [ccot_pkg::COORD_W-1:0] ref_e_q [3];
	logic [ccot_pkg::RAD_W-1:0]          ref_rad_q;
	logic signed [ccot_pkg::COORD_W-1:0] in_p_q [3];
	logic signed [ccot_pkg::COORD_W-1:0] in_e_q [3];
	logic [ccot_pkg::RAD_W-1:0]          in_rad_q;
	logic signed [ccot_pkg::DIFF_W-1:0]  d1_q [3];
	logic signed [ccot_pkg::DIFF_W-1:0]  d2_q [3];
	logic signed [ccot_pkg::DIFF_W-1:0]  r_q [3];
	logic [ccot_pkg::SQ_W-1:0]           rs_q;
	logic signed [ccot_pkg::OPW-1:0]     a_q, b_q, c_q, e_q, f_q;
	logic signed [ccot_pkg::OPW-1:0]     w_q [3];
	logic signed [ccot_pkg::ACC_W-1:0]   n_q, dn_q;
	logic [ccot_pkg::Q_W-1:0]            s_q, t_q;
	logic                                done_q;
	logic                                collide_q;
	logic [ccot_pkg::SQ_W-1:0]           sqd_q;

	logic signed [ccot_pkg::COORD_W-1:0] in_s [3];
	logic signed [ccot_pkg::COORD_W-1:0] in_e [3];
	logic [ccot_pkg::RAD_W:0]            rsum;
	logic [ccot_pkg::SQ_W-1:0]           rsq;
	logic signed [ccot_pkg::OPW-1:0]     mx, my;
	logic signed [ccot_pkg::ACC_W-1:0]   acc;
	logic                                mac_done;
	logic signed [ccot_pkg::ACC_W-1:0]   dnum, dden;
	logic [ccot_pkg::Q_W-1:0]            quo;
	logic                                div_done;
	logic                                sat;
	logic [ccot_pkg::SQ_W-1:0]           low;

	assign in_s[0] = start_x;
	assign in_s[1] = start_y;
	assign in_s[2] = start_z;
	assign in_e[0] = end_x;
	assign in_e[1] = end_y;
	assign in_e[2] = end_z;

	assign rsum = {1'b0, ref_rad_q} + {1'b0, in_rad_q};
	assign rsq  = rsum * rsum;

	function automatic logic signed [ccot_pkg::OPW-1:0] pick(input ccot_pkg::opnd_t o);
		logic signed [ccot_pkg::OPW-1:0] v;
		case (o)
			ccot_pkg::OP_D1X: v = ccot_pkg::OPW'(d1_q[0]);
			ccot_pkg::OP_D1Y: v = ccot_pkg::OPW'(d1_q[1]);
			ccot_pkg::OP_D1Z: v = ccot_pkg::OPW'(d1_q[2]);
			ccot_pkg::OP_D2X: v = ccot_pkg::OPW'(d2_q[0]);
			ccot_pkg::OP_D2Y: v = ccot_pkg::OPW'(d2_q[1]);
			ccot_pkg::OP_D2Z: v = ccot_pkg::OPW'(d2_q[2]);
			ccot_pkg::OP_RX:  v = ccot_pkg::OPW'(r_q[0]);
			ccot_pkg::OP_RY:  v = ccot_pkg::OPW'(r_q[1]);
			ccot_pkg::OP_RZ:  v = ccot_pkg::OPW'(r_q[2]);
			ccot_pkg::OP_A:   v = a_q;
			ccot_pkg::OP_B:   v = b_q;
			ccot_pkg::OP_C:   v = c_q;
			ccot_pkg::OP_E:   v = e_q;
			ccot_pkg::OP_F:   v = f_q;
			ccot_pkg::OP_S:   v = {{(ccot_pkg::OPW - ccot_pkg::Q_W){1'b0}}, s_q};
			ccot_pkg::OP_T:   v = {{(ccot_pkg::OPW - ccot_pkg::Q_W){1'b0}}, t_q};
			ccot_pkg::OP_ONE: v = {{(ccot_pkg::OPW - ccot_pkg::Q_W){1'b0}}, ccot_pkg::Q_ONE};
			ccot_pkg::OP_W0:  v = w_q[0];
			ccot_pkg::OP_W1:  v = w_q[1];
			ccot_pkg::OP_W2:  v = w_q[2];
			default:          v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mx = pick(cmd.xs);
		my = pick(cmd.ys);
	end

	always_comb begin
		case (cmd.dpair)
			ccot_pkg::DV_F_E: begin
				dnum = ccot_pkg::ACC_W'(f_q);
				dden = ccot_pkg::ACC_W'(e_q);
			end
			ccot_pkg::DV_NEGC_A: begin
				dnum = -ccot_pkg::ACC_W'(c_q);
				dden = ccot_pkg::ACC_W'(a_q);
			end
			ccot_pkg::DV_BMC_A: begin
				dnum = ccot_pkg::ACC_W'(b_q) - ccot_pkg::ACC_W'(c_q);
				dden = ccot_pkg::ACC_W'(a_q);
			end
			default: begin
				dnum = n_q;
				dden = dn_q;
			end
		endcase
	end

	ccot_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mac_go),
		.x      (mx),
		.y      (my),
		.nch    (cmd.nch),
		.neg    (cmd.neg),
		.clr    (cmd.clr),
		.acc    (acc),
		.done   (mac_done)
	);

	ccot_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (dnum),
		.den    (dden),
		.q      (quo),
		.done   (div_done)
	);

	// saturate when any bit above the Q48.0 window (acc bits 79:32) is set
	assign sat = |acc[ccot_pkg::ACC_W-1:SUM_TOP];
	assign low = acc[SUM_TOP-1:ccot_pkg::SUM_LSB];

	// reference capsule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ref_s_q[k] <= '0;
				ref_e_q[k] <= '0;
			end
			ref_rad_q <= '0;
		end else if (accept && !mode) begin
			for (int k = 0; k < 3; k++) begin
				ref_s_q[k] <= in_s[k];
				ref_e_q[k] <= in_e[k];
			end
			ref_rad_q <= radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out_go;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				in_p_q[k] <= in_s[k];
				in_e_q[k] <= in_e[k];
			end
			in_rad_q <= radius;
		end
		if (cmd.prep) begin
			for (int k = 0; k < 3; k++) begin
				d1_q[k] <= ccot_pkg::DIFF_W'(ref_e_q[k]) - ccot_pkg::DIFF_W'(ref_s_q[k]);
				d2_q[k] <= ccot_pkg::DIFF_W'(in_e_q[k]) - ccot_pkg::DIFF_W'(in_p_q[k]);
				r_q[k]  <= ccot_pkg::DIFF_W'(ref_s_q[k]) - ccot_pkg::DIFF_W'(in_p_q[k]);
			end
			rs_q <= rsq;
		end
		if (cmd.st_go) begin
			case (cmd.dst)
				ccot_pkg::DST_A:  a_q <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_B:  b_q <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_C:  c_q <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_E:  e_q <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_F:  f_q <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_N:  n_q <= acc;
				ccot_pkg::DST_DN: dn_q <= acc;
				ccot_pkg::DST_TD: dn_q <= ccot_pkg::ACC_W'(e_q) <<< ccot_pkg::Q_FRAC;
				ccot_pkg::DST_W0: w_q[0] <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_W1: w_q[1] <= acc[ccot_pkg::OPW-1:0];
				ccot_pkg::DST_W2: w_q[2] <= acc[ccot_pkg::OPW-1:0];
				default: ;
			endcase
		end
		if (cmd.set_go) begin
			case (cmd.setk)
				ccot_pkg::SET_T_ONE: t_q <= ccot_pkg::Q_ONE;
				default: begin
					s_q <= '0;
					t_q <= '0;
				end
			endcase
		end
		if (cmd.div_wr) begin
			if (cmd.to_t) begin
				t_q <= quo;
			end else begin
				s_q <= quo;
			end
		end
		if (cmd.out_go) begin
			sqd_q     <= sat ? ccot_pkg::SQ_MAX : low;
			collide_q <= !sat && (low < rs_q);
		end
	end

	always_comb begin
		stat.a_zero   = (a_q == '0);
		stat.e_zero   = (e_q == '0);
		stat.dn_zero  = (dn_q == '0);
		stat.n_neg    = n_q[ccot_pkg::ACC_W-1];
		stat.n_gt     = (dn_q < n_q);
		stat.mac_done = mac_done;
		stat.div_done = div_done;
	end

	assign done        = done_q;
	assign collide     = collide_q;
	assign sq_distance = sqd_q;

endmodule

[hdl/ccot_ctrl.sv]
// ------------------------------------------------------------------------
// ccot_ctrl
// Microcode sequencer: steps the program and issues datapath commands.
// ------------------------------------------------------------------------
module ccot_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            mode,
	input  ccot_pkg::stat_t stat,
	output ccot_pkg::cmd_t  cmd,
	output logic            busy
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_EXEC, ST_MACW, ST_DIVW, ST_DIVWR
	} state_t;

	state_t                      state_q;
	logic [ccot_pkg::PC_W-1:0]   pc_q;
	ccot_pkg::uop_t              uop;
	logic                        taken;

	assign uop  = ccot_pkg::ucode(pc_q);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		case (uop.cond)
			ccot_pkg::C_AE_ZERO: taken = stat.a_zero && stat.e_zero;
			ccot_pkg::C_A_ZERO:  taken = stat.a_zero;
			ccot_pkg::C_E_ZERO:  taken = stat.e_zero;
			ccot_pkg::C_DN_ZERO: taken = stat.dn_zero;
			ccot_pkg::C_N_NEG:   taken = stat.n_neg;
			ccot_pkg::C_N_GT:    taken = stat.n_gt;
			default:             taken = 1'b0;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.xs     = uop.xs;
		cmd.ys     = uop.ys;
		cmd.nch    = uop.nch;
		cmd.neg    = uop.neg;
		cmd.clr    = uop.clr;
		cmd.dst    = uop.dst;
		cmd.dpair  = uop.dpair;
		cmd.to_t   = uop.to_t;
		cmd.setk   = uop.setk;
		cmd.prep   = (state_q == ST_PREP);
		cmd.div_wr = (state_q == ST_DIVWR);
		if (state_q == ST_EXEC) begin
			cmd.mac_go = (uop.kind == ccot_pkg::UK_MAC);
			cmd.st_go  = (uop.kind == ccot_pkg::UK_ST);
			cmd.div_go = (uop.kind == ccot_pkg::UK_DIV);
			cmd.set_go = (uop.kind == ccot_pkg::UK_SET);
			cmd.out_go = (uop.kind == ccot_pkg::UK_OUT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && mode) begin
						state_q <= ST_PREP;
						pc_q    <= '0;
					end
				end
				ST_PREP: state_q <= ST_EXEC;
				ST_EXEC: begin
					case (uop.kind)
						ccot_pkg::UK_MAC: state_q <= ST_MACW;
						ccot_pkg::UK_DIV: state_q <= ST_DIVW;
						ccot_pkg::UK_BR:  pc_q <= taken ? uop.tgt : pc_q + 1'b1;
						ccot_pkg::UK_JMP: pc_q <= uop.tgt;
						ccot_pkg::UK_OUT: state_q <= ST_IDLE;
						default:          pc_q <= pc_q + 1'b1;
					endcase
				end
				ST_MACW: begin
					if (stat.mac_done) begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_EXEC;
					end
				end
				ST_DIVW: begin
					if (stat.div_done) begin
						state_q <= ST_DIVWR;
					end
				end
				ST_DIVWR: begin
					pc_q    <= pc_q + 1'b1;
					state_q <= ST_EXEC;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[verif/capsule_capsule_overlap_test_tb.sv]
// ------------------------------------------------------------------------
// capsule_capsule_overlap_test_tb
// Checks the capsule overlap block against a cycle-free closest-point
// predictor: directed degenerate, parallel, clamp and extreme cases, then random
// loads and tests with random gaps on the request side.
// ------------------------------------------------------------------------
module capsule_capsule_overlap_test_tb;

	typedef logic signed [159:0] wide_t;
	typedef struct packed {
		logic                       collide;
		logic [ccot_pkg::SQ_W-1:0]  sq_distance;
	} capsule_result_t;

	localparam bit MODE_LOAD = 1'b0;
	localparam bit MODE_TEST = 1'b1;
	localparam int IDLE_LIMIT = 4000;

	logic clk, arst_n, start, busy, mode, done, collide;
	logic signed [ccot_pkg::COORD_W-1:0] start_x, start_y, start_z, end_x, end_y, end_z;
	logic [ccot_pkg::RAD_W-1:0] radius;
	logic [ccot_pkg::SQ_W-1:0] sq_distance;

	logic signed [ccot_pkg::COORD_W-1:0] ref_p[3], ref_q[3];
	logic [ccot_pkg::RAD_W-1:0] ref_rad;
	capsule_result_t distance_queue[$];
	int fail_cnt = 0;
	int idle_cycles = 0;

	capsule_capsule_overlap_test dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic wide_t wx(input longint v);
		wide_t w;
		w = wide_t'(v);
		return w;
	endfunction

	// clamp(num/den) to [0,1] in Q1.16, truncated
	function automatic logic [ccot_pkg::Q_W-1:0] clamp_q16(input wide_t num, input wide_t den);
		wide_t q;
		if (num <= 0)
			return '0;
		if (num >= den)
			return ccot_pkg::Q_ONE;
		q = (num * 65536) / den;
		return q[ccot_pkg::Q_W-1:0];
	endfunction

	function automatic wide_t dot3(input longint x[3], input longint y[3]);
		wide_t s;
		s = '0;
		for (int k = 0; k < 3; k++)
			s += wx(x[k]) * wx(y[k]);
		return s;
	endfunction

	function automatic capsule_result_t closest_distance(
			input logic signed [ccot_pkg::COORD_W-1:0] p2[3],
			input logic signed [ccot_pkg::COORD_W-1:0] q2[3],
			input logic [ccot_pkg::RAD_W-1:0] rad);
		longint d1[3], d2[3], r[3];
		wide_t a, b, c, e, f, negc, den, tn, td, sum, dv;
		logic [ccot_pkg::Q_W-1:0] s, t;
		longint c1, c2;
		logic [63:0] low, rsq;
		capsule_result_t res;
		for (int k = 0; k < 3; k++) begin
			d1[k] = longint'(ref_q[k]) - longint'(ref_p[k]);
			d2[k] = longint'(q2[k]) - longint'(p2[k]);
			r[k] = longint'(ref_p[k]) - longint'(p2[k]);
		end
		a = dot3(d1, d1);
		e = dot3(d2, d2);
		f = dot3(d2, r);
		c = dot3(d1, r);
		b = dot3(d1, d2);
		negc = -c;
		s = '0;
		t = '0;
		if (a == 0 && e == 0) begin
			s = '0;
		end else if (a == 0) begin
			t = clamp_q16(f, e);
		end else if (e == 0) begin
			s = clamp_q16(negc, a);
		end else begin
			den = a * e - b * b;
			s = (den == 0) ? '0 : clamp_q16(b * f - c * e, den);
			tn = b * wx(longint'(s)) + f * 65536;
			td = e * 65536;
			if (tn < 0) begin
				t = '0;
				s = clamp_q16(negc, a);
			end else if (tn > td) begin
				t = ccot_pkg::Q_ONE;
				s = clamp_q16(b - c, a);
			end else begin
				t = clamp_q16(tn, td);
			end
		end
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			c1 = longint'(ref_p[k]) * 65536 + longint'(s) * d1[k];
			c2 = longint'(p2[k]) * 65536 + longint'(t) * d2[k];
			dv = wx(c1 - c2);
			sum += dv * dv;
		end
		rsq = 64'(ref_rad) + 64'(rad);
		rsq = rsq * rsq;
		low = sum[95:32];
		if (sum[159:96] != 0) begin
			res.collide = 1'b0;
			res.sq_distance = ccot_pkg::SQ_MAX;
		end else begin
			res.collide = low < rsq;
			res.sq_distance = (low > 64'(ccot_pkg::SQ_MAX)) ? ccot_pkg::SQ_MAX
				: low[ccot_pkg::SQ_W-1:0];
		end
		return res;
	endfunction

	task automatic send_request(input bit m,
			input logic signed [ccot_pkg::COORD_W-1:0] sx, sy, sz, ex, ey, ez,
			input logic [ccot_pkg::RAD_W-1:0] rad);
		logic signed [ccot_pkg::COORD_W-1:0] p2[3], q2[3];
		p2 = '{sx, sy, sz};
		q2 = '{ex, ey, ez};
		@(negedge clk);
		start = 1'b1;
		mode = m;
		start_x = sx; start_y = sy; start_z = sz;
		end_x = ex; end_y = ey; end_z = ez;
		radius = rad;
		do @(posedge clk); while (busy);
		if (m == MODE_LOAD) begin
			ref_p = p2;
			ref_q = q2;
			ref_rad = rad;
		end else begin
			distance_queue.push_back(closest_distance(p2, q2, rad));
		end
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic random_gap();
		int g, n;
		g = $urandom_range(0, 99);
		n = (g < 55) ? 0 : (g < 92) ? $urandom_range(1, 4) : $urandom_range(20, 120);
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_results();
		while (distance_queue.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic signed [ccot_pkg::COORD_W-1:0] rand_coord();
		logic signed [ccot_pkg::COORD_W-1:0] v;
		int pick;
		v = ccot_pkg::COORD_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return v;
		if (pick < 4)
			return v >>> 16;
		return v >>> $urandom_range(6, 13);
	endfunction

	task automatic test_degenerate();
		// reference still zero after reset: both segments points
		send_request(MODE_TEST, '0, '0, '0, '0, '0, '0, '0);
		send_request(MODE_TEST, 24'sd4096, '0, '0, 24'sd4096, '0, '0, 23'd4096);
		// reference a point, test a segment
		send_request(MODE_TEST, -24'sd8192, 24'sd100, '0, 24'sd8192, 24'sd100, '0, 23'd50);
		send_request(MODE_TEST, 24'sd100, 24'sd100, 24'sd5, 24'sd900, 24'sd300, 24'sd5, 23'd1);
		send_request(MODE_LOAD, '0, '0, '0, 24'sd40960, '0, '0, 23'd2048);
		// test segment a point, before, on and past the reference
		send_request(MODE_TEST, -24'sd4096, 24'sd100, '0, -24'sd4096, 24'sd100, '0, 23'd10);
		send_request(MODE_TEST, 24'sd20000, 24'sd1000, '0, 24'sd20000, 24'sd1000, '0, 23'd0);
		send_request(MODE_TEST, 24'sd90000, '0, 24'sd7, 24'sd90000, '0, 24'sd7, 23'd3);
	endtask

	task automatic test_parallel_and_clamp();
		send_request(MODE_TEST, 24'sd4096, 24'sd4096, '0, 24'sd20000, 24'sd4096, '0, 23'd2048);
		send_request(MODE_TEST, 24'sd50000, 24'sd500, '0, -24'sd9000, 24'sd500, '0, 23'd100);
		send_request(MODE_TEST, 24'sd20000, -24'sd8000, 24'sd3000, 24'sd20000, 24'sd8000,
			24'sd3000, 23'd7000);
		send_request(MODE_TEST, -24'sd30000, -24'sd30000, 24'sd10, -24'sd9000, -24'sd1000,
			24'sd10, 23'd1);
		send_request(MODE_TEST, 24'sd80000, 24'sd100, 24'sd100, 24'sd120000, 24'sd9000,
			-24'sd500, 23'd1);
		send_request(MODE_TEST, 24'sd1000, 24'sd3000, '0, 24'sd60000, -24'sd40000, '0, 23'd0);
	endtask

	task automatic test_extremes();
		logic signed [ccot_pkg::COORD_W-1:0] mx, mn;
		mx = {1'b0, {(ccot_pkg::COORD_W-1){1'b1}}};
		mn = {1'b1, {(ccot_pkg::COORD_W-1){1'b0}}};
		send_request(MODE_LOAD, mn, mn, mn, mx, mx, mx, {ccot_pkg::RAD_W{1'b1}});
		send_request(MODE_TEST, mx, mn, mx, mn, mx, mn, {ccot_pkg::RAD_W{1'b1}});
		send_request(MODE_TEST, mx, mx, mx, mx, mx, mx, '0);
		send_request(MODE_LOAD, mn, mn, mn, mn, mn, mn, '0);
		send_request(MODE_TEST, mx, mx, mx, mx, mx, mx, {ccot_pkg::RAD_W{1'b1}});
		send_request(MODE_TEST, mn, mn, mn, mx, mx, mx, 23'd1);
		send_request(MODE_LOAD, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 23'd1);
		send_request(MODE_TEST, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, 23'd1);
	endtask

	task automatic test_random(input int n_items);
		logic signed [ccot_pkg::COORD_W-1:0] p[3], q[3];
		logic [ccot_pkg::RAD_W-1:0] rad;
		int kind;
		for (int i = 0; i < n_items; i++) begin
			for (int k = 0; k < 3; k++) begin
				p[k] = rand_coord();
				q[k] = rand_coord();
			end
			rad = ($urandom_range(0, 4) == 0) ? ccot_pkg::RAD_W'($urandom)
				: ccot_pkg::RAD_W'($urandom >> 15);
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				send_request(MODE_LOAD, p[0], p[1], p[2], q[0], q[1], q[2], rad);
			end else begin
				// shape some tests: point segments and parallel copies of the reference
				if (kind < 14)
					q = p;
				else if (kind < 22)
					for (int k = 0; k < 3; k++) begin
						p[k] = ref_p[k] + (p[k] >>> 4);
						q[k] = ref_q[k] + (p[k] - ref_p[k]);
					end
				send_request(MODE_TEST, p[0], p[1], p[2], q[0], q[1], q[2], rad);
			end
			if (i == n_items / 2)
				drain_results();
			random_gap();
		end
	endtask

	// results: compare against the oldest prediction
	always @(posedge clk) begin
		capsule_result_t exp_res;
		if (arst_n && done) begin
			if (distance_queue.size() == 0) begin
				$error("unexpected result");
				fail_cnt++;
			end else begin
				exp_res = distance_queue.pop_front();
				if (collide !== exp_res.collide) begin
					$error("collide: expected %0d, got %0d", exp_res.collide, collide);
					fail_cnt++;
				end
				if (sq_distance !== exp_res.sq_distance) begin
					$error("sq_distance: expected %0h, got %0h",
						exp_res.sq_distance, sq_distance);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("[capsule_capsule_overlap_test] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		start_x = '0; start_y = '0; start_z = '0;
		end_x = '0; end_y = '0; end_z = '0;
		radius = '0;
		ref_p = '{default: '0};
		ref_q = '{default: '0};
		ref_rad = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_degenerate();
		test_parallel_and_clamp();
		test_extremes();
		test_random(1630);
		drain_results();
		repeat (200) @(posedge clk);
		if (fail_cnt == 0 && distance_queue.size() == 0)
			$display("[capsule_capsule_overlap_test] OK");
		else
			$display("[capsule_capsule_overlap_test] ERROR");
		$finish;
	end

endmodule
